// ----- hdl/quaternion_rigid_transform_macros.svh -----
// assertion macros shared by the rigid transform rtl
`ifndef QUATERNION_RIGID_TRANSFORM_MACROS_SVH
`define QUATERNION_RIGID_TRANSFORM_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define QRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrt: implication check failed");

// next-cycle implication, checked on every rising edge out of reset
`define QRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrt: next-cycle check failed");

`endif

// ----- hdl/qrt_pkg.sv -----
// types and constants of the quaternion rigid transform
`default_nettype none

package qrt_pkg;

    // quaternion component of 1.0 in q2.14
    localparam logic signed [17:0] ONE_Q14 = 18'sd16384;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ROT_W   = 3'd0,
        REG_ROT_X   = 3'd1,
        REG_ROT_Y   = 3'd2,
        REG_ROT_Z   = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6,
        REG_ID_TOL  = 3'd7
    } cfg_reg_t;

    // operation codes
    localparam logic OP_POINT  = 1'b0;
    localparam logic OP_VECTOR = 1'b1;

    // three q16.16 coordinates
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec3_t;

    // cross product terms, q.30
    typedef struct packed {
        logic signed [47:0] yz;
        logic signed [47:0] zy;
        logic signed [47:0] zx;
        logic signed [47:0] xz;
        logic signed [47:0] xy;
        logic signed [47:0] yx;
    } cross1_t;

    // u x v rounded to q.16
    typedef struct packed {
        logic signed [34:0] x;
        logic signed [34:0] y;
        logic signed [34:0] z;
    } uv_t;

    // stage 3 products, q.30
    typedef struct packed {
        logic signed [50:0] wx;
        logic signed [50:0] yz;
        logic signed [50:0] zy;
        logic signed [50:0] wy;
        logic signed [50:0] zx;
        logic signed [50:0] xz;
        logic signed [50:0] wz;
        logic signed [50:0] xy;
        logic signed [50:0] yx;
    } cross2_t;

    // rotation offset in q.16
    typedef struct packed {
        logic signed [39:0] x;
        logic signed [39:0] y;
        logic signed [39:0] z;
    } offset_t;

endpackage

`default_nettype wire

// ----- hdl/quaternion_rigid_transform.sv -----
// quaternion rigid transform: five-stage pipeline for points and direction vectors
// a transfer passes the s1 to s4 registers and the output registers, and done marks its result
// throughput: one item per cycle while busy is low, set by the fully pipelined multiplier stages
// the identity flag runs in a two-stage side pipeline fed by the configuration registers
// reset: busy and cfg_ready are held off by a registered init flag after reset, pipeline valids clear
// config resets to the identity transform with tolerance 66
`default_nettype none

`include "quaternion_rigid_transform_macros.svh"

module quaternion_rigid_transform
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // command channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               operation,
    input  wire logic signed [31:0] coord_x,
    input  wire logic signed [31:0] coord_y,
    input  wire logic signed [31:0] coord_z,
    // result channel
    output logic                    done,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic                    is_identity,
    // configuration channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    // configuration registers
    logic signed [15:0] rot_w_reg;
    logic signed [15:0] rot_x_reg;
    logic signed [15:0] rot_y_reg;
    logic signed [15:0] rot_z_reg;
    logic signed [31:0] shift_x_reg;
    logic signed [31:0] shift_y_reg;
    logic signed [31:0] shift_z_reg;
    logic [30:0]        id_tol_reg;
    logic               init_reg;

    logic cfg_write;
    logic in_accept;

    assign busy      = init_reg;
    assign cfg_ready = !init_reg;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_accept = start && !busy;

    // hold-off after reset, cleared by the next clock edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= 1'b1;
        end
        else
        begin
            init_reg <= 1'b0;
        end
    end

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_w_reg   <= 16'sd16384;
            rot_x_reg   <= '0;
            rot_y_reg   <= '0;
            rot_z_reg   <= '0;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            shift_z_reg <= '0;
            id_tol_reg  <= 31'd66;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                qrt_pkg::REG_ROT_W:   rot_w_reg   <= cfg_data[15:0];
                qrt_pkg::REG_ROT_X:   rot_x_reg   <= cfg_data[15:0];
                qrt_pkg::REG_ROT_Y:   rot_y_reg   <= cfg_data[15:0];
                qrt_pkg::REG_ROT_Z:   rot_z_reg   <= cfg_data[15:0];
                qrt_pkg::REG_SHIFT_X: shift_x_reg <= cfg_data;
                qrt_pkg::REG_SHIFT_Y: shift_y_reg <= cfg_data;
                qrt_pkg::REG_SHIFT_Z: shift_z_reg <= cfg_data;
                qrt_pkg::REG_ID_TOL:  id_tol_reg  <= cfg_data[30:0];
                default:              id_tol_reg  <= id_tol_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // main datapath
    // ------------------------------------------------------------------
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic               s1_op_reg, s2_op_reg, s3_op_reg;
    qrt_pkg::vec3_t     s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    qrt_pkg::cross1_t   s1_p_reg, s1_p_next;
    qrt_pkg::uv_t       s2_uv_reg, s2_uv_next;
    qrt_pkg::cross2_t   s3_p_reg, s3_p_next;
    qrt_pkg::offset_t   s4_off_reg, s4_off_next;
    qrt_pkg::vec3_t     s4_trans_reg, s4_trans_next;

    logic               done_reg;
    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic signed [31:0] out_x_next, out_y_next, out_z_next;
    logic               is_identity_reg;
    logic               id_flag_reg;

    logic signed [48:0] diff_x, diff_y, diff_z;
    logic signed [52:0] t_x, t_y, t_z;
    logic signed [41:0] r_x, r_y, r_z;

    // stage 1: u x v products
    always_comb
    begin
        s1_p_next.yz = rot_y_reg * coord_z;
        s1_p_next.zy = rot_z_reg * coord_y;
        s1_p_next.zx = rot_z_reg * coord_x;
        s1_p_next.xz = rot_x_reg * coord_z;
        s1_p_next.xy = rot_x_reg * coord_y;
        s1_p_next.yx = rot_y_reg * coord_x;
    end

    // stage 2: differences rounded to q.16
    always_comb
    begin
        diff_x = 49'(s1_p_reg.yz) - 49'(s1_p_reg.zy);
        diff_y = 49'(s1_p_reg.zx) - 49'(s1_p_reg.xz);
        diff_z = 49'(s1_p_reg.xy) - 49'(s1_p_reg.yx);
        s2_uv_next.x = 35'((diff_x + 49'sd8192) >>> 14);
        s2_uv_next.y = 35'((diff_y + 49'sd8192) >>> 14);
        s2_uv_next.z = 35'((diff_z + 49'sd8192) >>> 14);
    end

    // stage 3: w*uv and u x uv products
    always_comb
    begin
        s3_p_next.wx = rot_w_reg * s2_uv_reg.x;
        s3_p_next.yz = rot_y_reg * s2_uv_reg.z;
        s3_p_next.zy = rot_z_reg * s2_uv_reg.y;
        s3_p_next.wy = rot_w_reg * s2_uv_reg.y;
        s3_p_next.zx = rot_z_reg * s2_uv_reg.x;
        s3_p_next.xz = rot_x_reg * s2_uv_reg.z;
        s3_p_next.wz = rot_w_reg * s2_uv_reg.z;
        s3_p_next.xy = rot_x_reg * s2_uv_reg.y;
        s3_p_next.yx = rot_y_reg * s2_uv_reg.x;
    end

    // stage 4: sum, double and round to q.16, pick translation
    always_comb
    begin
        t_x = 53'(s3_p_reg.wx) + 53'(s3_p_reg.yz) - 53'(s3_p_reg.zy);
        t_y = 53'(s3_p_reg.wy) + 53'(s3_p_reg.zx) - 53'(s3_p_reg.xz);
        t_z = 53'(s3_p_reg.wz) + 53'(s3_p_reg.xy) - 53'(s3_p_reg.yx);
        s4_off_next.x = 40'((t_x + 53'sd4096) >>> 13);
        s4_off_next.y = 40'((t_y + 53'sd4096) >>> 13);
        s4_off_next.z = 40'((t_z + 53'sd4096) >>> 13);
        if (s3_op_reg == qrt_pkg::OP_VECTOR)
        begin
            s4_trans_next = '0;
        end
        else
        begin
            s4_trans_next.x = shift_x_reg;
            s4_trans_next.y = shift_y_reg;
            s4_trans_next.z = shift_z_reg;
        end
    end

    // stage 5: final add and saturation
    always_comb
    begin
        r_x = 42'(s4_v_reg.x) + 42'(s4_off_reg.x) + 42'(s4_trans_reg.x);
        r_y = 42'(s4_v_reg.y) + 42'(s4_off_reg.y) + 42'(s4_trans_reg.y);
        r_z = 42'(s4_v_reg.z) + 42'(s4_off_reg.z) + 42'(s4_trans_reg.z);
        out_x_next = r_x[31:0];
        out_y_next = r_y[31:0];
        out_z_next = r_z[31:0];
        if (r_x > 42'sh7FFFFFFF)
        begin
            out_x_next = 32'sh7FFFFFFF;
        end
        else if (r_x < -42'sh80000000)
        begin
            out_x_next = 32'sh80000000;
        end
        if (r_y > 42'sh7FFFFFFF)
        begin
            out_y_next = 32'sh7FFFFFFF;
        end
        else if (r_y < -42'sh80000000)
        begin
            out_y_next = 32'sh80000000;
        end
        if (r_z > 42'sh7FFFFFFF)
        begin
            out_z_next = 32'sh7FFFFFFF;
        end
        else if (r_z < -42'sh80000000)
        begin
            out_z_next = 32'sh80000000;
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    // pipeline payload, loaded only when a transfer moves into the stage
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg  <= operation;
            s1_v_reg.x <= coord_x;
            s1_v_reg.y <= coord_y;
            s1_v_reg.z <= coord_z;
            s1_p_reg   <= s1_p_next;
        end
        if (s1_valid_reg)
        begin
            s2_op_reg <= s1_op_reg;
            s2_v_reg  <= s1_v_reg;
            s2_uv_reg <= s2_uv_next;
        end
        if (s2_valid_reg)
        begin
            s3_op_reg <= s2_op_reg;
            s3_v_reg  <= s2_v_reg;
            s3_p_reg  <= s3_p_next;
        end
        if (s3_valid_reg)
        begin
            s4_v_reg     <= s3_v_reg;
            s4_off_reg   <= s4_off_next;
            s4_trans_reg <= s4_trans_next;
        end
        if (s4_valid_reg)
        begin
            out_x_reg       <= out_x_next;
            out_y_reg       <= out_y_next;
            out_z_reg       <= out_z_next;
            is_identity_reg <= id_flag_reg;
        end
    end

    assign done        = done_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_z       = out_z_reg;
    assign is_identity = is_identity_reg;

    // ------------------------------------------------------------------
    // identity test side pipeline, follows the configuration registers
    // ------------------------------------------------------------------
    logic [63:0] id_sx2_reg, id_sy2_reg, id_sz2_reg;
    logic [61:0] id_tol2_reg;
    logic [30:0] id_ux2_reg, id_uy2_reg, id_uz2_reg;
    logic [14:0] id_adw_reg;
    logic [30:0] id_tol_d_reg;

    logic [31:0]        abs_sx, abs_sy, abs_sz;
    logic signed [17:0] w_ext, w_abs, w_dev, w_adev;
    logic signed [31:0] ux2_full, uy2_full, uz2_full;
    logic [63:0]        t2_sum;
    logic [32:0]        u2_sum;
    logic               id_flag_next;

    // magnitudes of the translation and of the scalar deviation
    always_comb
    begin
        abs_sx = shift_x_reg[31] ? 32'(-shift_x_reg) : 32'(shift_x_reg);
        abs_sy = shift_y_reg[31] ? 32'(-shift_y_reg) : 32'(shift_y_reg);
        abs_sz = shift_z_reg[31] ? 32'(-shift_z_reg) : 32'(shift_z_reg);
        w_ext  = 18'(rot_w_reg);
        w_abs  = (w_ext < 18'sd0) ? -w_ext : w_ext;
        w_dev  = w_abs - qrt_pkg::ONE_Q14;
        w_adev = (w_dev < 18'sd0) ? -w_dev : w_dev;
        ux2_full = rot_x_reg * rot_x_reg;
        uy2_full = rot_y_reg * rot_y_reg;
        uz2_full = rot_z_reg * rot_z_reg;
    end

    // sums and the three threshold compares
    always_comb
    begin
        t2_sum = id_sx2_reg + id_sy2_reg + id_sz2_reg;
        u2_sum = 33'(id_ux2_reg) + 33'(id_uy2_reg) + 33'(id_uz2_reg);
        id_flag_next = 1'b1;
        if (t2_sum > 64'(id_tol2_reg))
        begin
            id_flag_next = 1'b0;
        end
        if (33'({id_adw_reg, 2'b00}) > 33'(id_tol_d_reg))
        begin
            id_flag_next = 1'b0;
        end
        if (62'({u2_sum, 4'b0000}) > id_tol2_reg)
        begin
            id_flag_next = 1'b0;
        end
    end

    // squares, then flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_sx2_reg   <= '0;
            id_sy2_reg   <= '0;
            id_sz2_reg   <= '0;
            id_tol2_reg  <= '0;
            id_ux2_reg   <= '0;
            id_uy2_reg   <= '0;
            id_uz2_reg   <= '0;
            id_adw_reg   <= '0;
            id_tol_d_reg <= '0;
            id_flag_reg  <= 1'b0;
        end
        else
        begin
            id_sx2_reg   <= abs_sx * abs_sx;
            id_sy2_reg   <= abs_sy * abs_sy;
            id_sz2_reg   <= abs_sz * abs_sz;
            id_tol2_reg  <= id_tol_reg * id_tol_reg;
            id_ux2_reg   <= ux2_full[30:0];
            id_uy2_reg   <= uy2_full[30:0];
            id_uz2_reg   <= uz2_full[30:0];
            id_adw_reg   <= w_adev[14:0];
            id_tol_d_reg <= id_tol_reg;
            id_flag_reg  <= id_flag_next;
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // every accepted transfer comes out with done after the s1 to s4 registers and the output registers
    `QRT_ASSERT_IMPL(a_fixed_latency, clk, rst_n, $past(rst_n, 5), done == $past(in_accept, 5))
    // hold-off ends in the cycle after reset is released
    `QRT_ASSERT_IMPL(a_ready_after_init, clk, rst_n, $past(rst_n), !busy && cfg_ready)
    // identity flag is stable once the last register write has run through the square and flag registers
    `QRT_ASSERT_IMPL(a_id_flag_settled, clk, rst_n, $past(rst_n, 3) && !$past(cfg_write, 1) && !$past(cfg_write, 2) && !$past(cfg_write, 3), $stable(id_flag_reg))
    // a transfer in the last stage always produces the strobe
    `QRT_ASSERT_NEXT(a_done_follows, clk, rst_n, s4_valid_reg, done)

endmodule

`default_nettype wire
